// ----- rtl/core/masked_rgba_to_yuv420_converter_defines.svh -----
// Assertion macros shared by the converter RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef MASKED_RGBA_TO_YUV420_CONVERTER_DEFINES_SVH
`define MASKED_RGBA_TO_YUV420_CONVERTER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define RGB2YUV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define RGB2YUV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/rgb2yuv_pkg.sv -----
// Types, constants and product tables for the RGBA to YUV 4:2:0 converter.
// No dependencies.
package rgb2yuv_pkg;

    localparam int MAX_DIMENSION_DEF = 4096;

    localparam int PIX_W      = 8;
    localparam int FRAME_W    = 13;     // frame size register width
    localparam int WIN_W      = 12;     // window edge register width
    localparam int DIM_W      = 17;     // holds any coordinate up to 131071
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST   = 13'd1280;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST  = 13'd720;
    localparam logic [WIN_W-1:0]   WINDOW_LEFT_RST   = 12'd0;
    localparam logic [WIN_W-1:0]   WINDOW_RIGHT_RST  = 12'd1279;
    localparam logic [WIN_W-1:0]   WINDOW_TOP_RST    = 12'd0;
    localparam logic [WIN_W-1:0]   WINDOW_BOTTOM_RST = 12'd719;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_WINDOW_LEFT   = 3'd2,
        REG_WINDOW_RIGHT  = 3'd3,
        REG_WINDOW_TOP    = 3'd4,
        REG_WINDOW_BOTTOM = 3'd5
    } cfg_reg_t;

    // Fixed point: products carry 16 fraction bits.
    localparam int FRAC_BITS  = 16;
    localparam int HALF_SHIFT = 15;
    localparam int ROM_W      = 24;
    localparam int SUM_W      = 25;
    localparam longint unsigned ROM_SCALE = 64'd10000;   // coefficients are in 1e-4
    localparam longint unsigned ONE_FRAC  = 64'd65536;
    localparam logic [SUM_W-1:0] CHROMA_BIAS = 25'h0800000;

    localparam int unsigned COEF_Y_R = 2990;
    localparam int unsigned COEF_Y_G = 5870;
    localparam int unsigned COEF_Y_B = 1140;
    localparam int unsigned COEF_U_R = 1684;
    localparam int unsigned COEF_U_G = 3316;
    localparam int unsigned COEF_V_G = 4187;
    localparam int unsigned COEF_V_B = 813;

    typedef logic [ROM_W-1:0] rom_t [256];

    // Entry x = floor(coef * x * 65536 / 10000), evaluated at elaboration.
    function automatic rom_t build_rom(input int unsigned coef_e4);
        rom_t            t;
        longint unsigned p;
        for (int x = 0; x < 256; x++)
        begin
            p    = longint'(coef_e4) * longint'(x) * ONE_FRAC;
            t[x] = ROM_W'(p / ROM_SCALE);
        end
        return t;
    endfunction

    localparam rom_t ROM_Y_R = build_rom(COEF_Y_R);
    localparam rom_t ROM_Y_G = build_rom(COEF_Y_G);
    localparam rom_t ROM_Y_B = build_rom(COEF_Y_B);
    localparam rom_t ROM_U_R = build_rom(COEF_U_R);
    localparam rom_t ROM_U_G = build_rom(COEF_U_G);
    localparam rom_t ROM_V_G = build_rom(COEF_V_G);
    localparam rom_t ROM_V_B = build_rom(COEF_V_B);

    // Effective window, all in frame coordinates.
    typedef struct packed {
        logic [DIM_W-1:0] last_col;
        logic [DIM_W-1:0] last_row;
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] bottom;
    } win_cfg_t;

    // Masked pixel with its position flags.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
        logic             chroma_valid;
        logic             frame_last;
    } px_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] masked_red;
        logic [PIX_W-1:0] masked_green;
        logic [PIX_W-1:0] masked_blue;
        logic [PIX_W-1:0] masked_alpha;
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             chroma_valid;
        logic             frame_last;
    } res_t;

endpackage

// ----- rtl/core/rgb2yuv_if.sv -----
// Channel interfaces of the converter: pixel in, result out, register writes.
// Depends on rgb2yuv_pkg.
interface rgb2yuv_pixel_if;
    import rgb2yuv_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rgb2yuv_result_if;
    import rgb2yuv_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] masked_red;
    logic [PIX_W-1:0] masked_green;
    logic [PIX_W-1:0] masked_blue;
    logic [PIX_W-1:0] masked_alpha;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             chroma_valid;
    logic             frame_last;
    modport source (output valid, masked_red, masked_green, masked_blue, masked_alpha,
                    luma, chroma_blue, chroma_red, chroma_valid, frame_last,
                    input ready);
    modport sink   (input valid, masked_red, masked_green, masked_blue, masked_alpha,
                    luma, chroma_blue, chroma_red, chroma_valid, frame_last,
                    output ready);
endinterface

interface rgb2yuv_cfg_if;
    import rgb2yuv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/masked_rgba_to_yuv420_converter.sv -----
// Top level of the masked RGBA to YUV 4:2:0 converter.
// Depends on rgb2yuv_pkg, the channel interfaces, rgb2yuv_cfg_regs,
// rgb2yuv_window, rgb2yuv_csc and the assertion macro header.
//
// Usage:
//   pixel  - RGBA items in raster order, valid/ready. Column and row are
//            counted against frame_width x frame_height; the frame wraps
//            after its last pixel.
//   result - one item per pixel: masked RGBA (zero outside the window),
//            luma (BT.601 full range), chroma at odd row and odd column
//            only (zero elsewhere), and a frame_last flag.
//   cfg    - register writes (index, data), always ready, applied on the
//            next edge. Write only while no pixel is in flight; counters
//            are not touched by writes.
// Path: an accepted pixel enters the mask register, then passes the table
//   lookups and sums into the result register.
// Throughput: one item per cycle; both stages move together when the
//   result is taken every cycle.
// Stall: when result.ready is low the result register holds, the mask
//   stage takes one more pixel only if it was empty, then pixel.ready drops.
// Reset: counters at zero, pipeline empty, registers at 1280x720 with the
//   window covering the full frame.
`include "masked_rgba_to_yuv420_converter_defines.svh"

module masked_rgba_to_yuv420_converter #(
    parameter int MaxDimension = rgb2yuv_pkg::MAX_DIMENSION_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rgb2yuv_pixel_if.sink    pixel,
    rgb2yuv_result_if.source result,
    rgb2yuv_cfg_if.sink      cfg
);
    import rgb2yuv_pkg::*;

    win_cfg_t win;
    px_item_t item;
    res_t     res;
    logic     item_valid, res_valid;
    logic     load, accept;

    // Mask stage moves on when the result register is empty or being taken.
    assign load   = item_valid && (!res_valid || result.ready);
    assign accept = pixel.valid && pixel.ready;

    assign pixel.ready = !item_valid || load;
    assign cfg.ready   = 1'b1;

    rgb2yuv_cfg_regs #(
        .MaxDimension (MaxDimension)
    ) u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .win      (win)
    );

    rgb2yuv_window #(
        .MaxDimension (MaxDimension)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .win        (win),
        .accept     (accept),
        .red        (pixel.red),
        .green      (pixel.green),
        .blue       (pixel.blue),
        .alpha      (pixel.alpha),
        .drain      (load),
        .item_valid (item_valid),
        .item       (item)
    );

    rgb2yuv_csc u_csc (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .drain     (result.ready),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result.valid        = res_valid;
    assign result.masked_red   = res.masked_red;
    assign result.masked_green = res.masked_green;
    assign result.masked_blue  = res.masked_blue;
    assign result.masked_alpha = res.masked_alpha;
    assign result.luma         = res.luma;
    assign result.chroma_blue  = res.chroma_blue;
    assign result.chroma_red   = res.chroma_red;
    assign result.chroma_valid = res.chroma_valid;
    assign result.frame_last   = res.frame_last;

    `RGB2YUV_ASSERT(a_chroma_zero, result.valid && !result.chroma_valid |-> result.chroma_blue == '0 && result.chroma_red == '0, "chroma not zero off chroma sites")
    `RGB2YUV_ASSERT(a_black_luma, result.valid && result.masked_red == '0 && result.masked_green == '0 && result.masked_blue == '0 |-> result.luma == '0, "black pixel with nonzero luma")
    `RGB2YUV_ASSERT(a_load_fills, load |=> res_valid, "result register not filled after load")
    `RGB2YUV_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !res_valid && !item_valid, "pipeline not empty in reset")

endmodule

// ----- rtl/core/rgb2yuv_cfg_regs.sv -----
// Configuration registers and the effective (clamped) frame window.
// Depends on rgb2yuv_pkg.
module rgb2yuv_cfg_regs #(
    parameter int MaxDimension = rgb2yuv_pkg::MAX_DIMENSION_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [rgb2yuv_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [rgb2yuv_pkg::CFG_DATA_W-1:0] wr_data,
    output rgb2yuv_pkg::win_cfg_t              win
);
    import rgb2yuv_pkg::*;

    localparam logic [DIM_W-1:0] MAX_LAST = DIM_W'(MaxDimension - 1);

    logic [FRAME_W-1:0] width_reg, height_reg;
    logic [WIN_W-1:0]   left_reg, right_reg, top_reg, bottom_reg;
    logic [DIM_W-1:0]   last_col, last_row, right_ext, bottom_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FRAME_WIDTH_RST;
            height_reg <= FRAME_HEIGHT_RST;
            left_reg   <= WINDOW_LEFT_RST;
            right_reg  <= WINDOW_RIGHT_RST;
            top_reg    <= WINDOW_TOP_RST;
            bottom_reg <= WINDOW_BOTTOM_RST;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_FRAME_WIDTH:   width_reg  <= wr_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT:  height_reg <= wr_data[FRAME_W-1:0];
                REG_WINDOW_LEFT:   left_reg   <= wr_data[WIN_W-1:0];
                REG_WINDOW_RIGHT:  right_reg  <= wr_data[WIN_W-1:0];
                REG_WINDOW_TOP:    top_reg    <= wr_data[WIN_W-1:0];
                REG_WINDOW_BOTTOM: bottom_reg <= wr_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Size zero acts as one, above the maximum acts as the maximum.
    always_comb
    begin
        if (width_reg == '0)
            last_col = '0;
        else if (32'(width_reg) > 32'(MaxDimension))
            last_col = MAX_LAST;
        else
            last_col = DIM_W'(width_reg) - DIM_W'(1);

        if (height_reg == '0)
            last_row = '0;
        else if (32'(height_reg) > 32'(MaxDimension))
            last_row = MAX_LAST;
        else
            last_row = DIM_W'(height_reg) - DIM_W'(1);

        right_ext  = DIM_W'(right_reg);
        bottom_ext = DIM_W'(bottom_reg);

        win.last_col = last_col;
        win.last_row = last_row;
        win.left     = DIM_W'(left_reg);
        win.top      = DIM_W'(top_reg);
        win.right    = (right_ext < last_col) ? right_ext : last_col;
        win.bottom   = (bottom_ext < last_row) ? bottom_ext : last_row;
    end

endmodule

// ----- rtl/core/rgb2yuv_window.sv -----
// Raster position counters, window mask and the input pipeline register.
// Depends on rgb2yuv_pkg and the assertion macro header.
`include "masked_rgba_to_yuv420_converter_defines.svh"

module rgb2yuv_window #(
    parameter int MaxDimension = rgb2yuv_pkg::MAX_DIMENSION_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rgb2yuv_pkg::win_cfg_t         win,
    input  logic                          accept,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] red,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] green,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] blue,
    input  logic [rgb2yuv_pkg::PIX_W-1:0] alpha,
    input  logic                          drain,
    output logic                          item_valid,
    output rgb2yuv_pkg::px_item_t         item
);
    import rgb2yuv_pkg::*;

    localparam int CW = (MaxDimension > 1) ? $clog2(MaxDimension) : 1;

    logic [CW-1:0]    col_reg, col_next, row_reg, row_next;
    logic [DIM_W-1:0] col_ext, row_ext;
    logic             visible, row_end, last;
    logic             valid_reg, valid_next;
    px_item_t         item_reg, item_next;

    always_comb
    begin
        col_ext = DIM_W'(col_reg);
        row_ext = DIM_W'(row_reg);
        visible = (col_ext >= win.left) && (col_ext <= win.right) &&
                  (row_ext >= win.top)  && (row_ext <= win.bottom);
        row_end = col_ext >= win.last_col;
        last    = row_end && (row_ext >= win.last_row);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        item_next.red          = visible ? red   : '0;
        item_next.green        = visible ? green : '0;
        item_next.blue         = visible ? blue  : '0;
        item_next.alpha        = visible ? alpha : '0;
        item_next.chroma_valid = col_reg[0] & row_reg[0];
        item_next.frame_last   = last;

        if (accept)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

    `RGB2YUV_ASSERT(a_frame_wrap, accept && last |=> col_reg == '0 && row_reg == '0, "position did not wrap at frame end")
    `RGB2YUV_ASSERT(a_pos_hold, !accept |=> $stable(col_reg) && $stable(row_reg), "position moved without an item")
    `RGB2YUV_ASSERT(a_chroma_odd, accept |=> item_reg.chroma_valid == ($past(col_reg[0]) && $past(row_reg[0])), "chroma flag off odd position")

endmodule

// ----- rtl/core/rgb2yuv_csc.sv -----
// Color conversion from table products and the result register.
// Depends on rgb2yuv_pkg.
module rgb2yuv_csc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  drain,
    input  rgb2yuv_pkg::px_item_t item,
    output logic                  res_valid,
    output rgb2yuv_pkg::res_t     res
);
    import rgb2yuv_pkg::*;

    logic [SUM_W-1:0] y_sum, u_sum, v_sum;
    logic             valid_reg, valid_next;
    res_t             res_reg, res_next;

    always_comb
    begin
        y_sum = SUM_W'(ROM_Y_R[item.red]) + SUM_W'(ROM_Y_G[item.green]) +
                SUM_W'(ROM_Y_B[item.blue]);
        u_sum = CHROMA_BIAS + (SUM_W'(item.blue) << HALF_SHIFT) -
                SUM_W'(ROM_U_R[item.red]) - SUM_W'(ROM_U_G[item.green]);
        v_sum = CHROMA_BIAS + (SUM_W'(item.red) << HALF_SHIFT) -
                SUM_W'(ROM_V_G[item.green]) - SUM_W'(ROM_V_B[item.blue]);

        res_next.masked_red   = item.red;
        res_next.masked_green = item.green;
        res_next.masked_blue  = item.blue;
        res_next.masked_alpha = item.alpha;
        res_next.luma         = y_sum[FRAC_BITS +: PIX_W];
        res_next.chroma_blue  = item.chroma_valid ? u_sum[FRAC_BITS +: PIX_W] : '0;
        res_next.chroma_red   = item.chroma_valid ? v_sum[FRAC_BITS +: PIX_W] : '0;
        res_next.chroma_valid = item.chroma_valid;
        res_next.frame_last   = item.frame_last;

        if (load)
            valid_next = 1'b1;
        else if (drain)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ----- test/yuv_check_pkg.sv -----
`timescale 1ns / 1ps
// Scoreboard for the masked RGBA to YUV 4:2:0 converter: its own copy of the
// registers and the pixel position, and the queue of expected result items.
// Depends on rgb2yuv_pkg.
package yuv_check_pkg;
    import rgb2yuv_pkg::*;

    class yuv_scoreboard;
        logic [FRAME_W-1:0] frame_width;
        logic [FRAME_W-1:0] frame_height;
        logic [WIN_W-1:0]   win_left;
        logic [WIN_W-1:0]   win_right;
        logic [WIN_W-1:0]   win_top;
        logic [WIN_W-1:0]   win_bottom;
        int unsigned        col;
        int unsigned        row;
        res_t               expected_yuv[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        chroma_samples;
        int unsigned        frames_done;
        int unsigned        masked_pixels;
        int unsigned        reg_writes;

        function new();
            frame_width  = FRAME_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            win_left     = WINDOW_LEFT_RST;
            win_right    = WINDOW_RIGHT_RST;
            win_top      = WINDOW_TOP_RST;
            win_bottom   = WINDOW_BOTTOM_RST;
            col          = 0;
            row          = 0;
        endfunction

        function int unsigned pending();
            return expected_yuv.size();
        endfunction

        // floor(coef * x * 65536), coef given in units of 1e-4
        static function int unsigned scaled(int unsigned coef_e4, logic [PIX_W-1:0] x);
            longint unsigned p;
            p = coef_e4;
            p = p * x * 64'd65536;
            return int'(p / 64'd10000);
        endfunction

        // zero acts as 1, anything past the limit as the limit
        static function int unsigned clamp_dim(logic [FRAME_W-1:0] d);
            if (d == 0)
                return 1;
            if (d > MAX_DIMENSION_DEF)
                return MAX_DIMENSION_DEF;
            return d;
        endfunction

        function void apply_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            reg_writes++;
            case (idx)
                REG_FRAME_WIDTH:   frame_width  = val;
                REG_FRAME_HEIGHT:  frame_height = val;
                REG_WINDOW_LEFT:   win_left     = val[WIN_W-1:0];
                REG_WINDOW_RIGHT:  win_right    = val[WIN_W-1:0];
                REG_WINDOW_TOP:    win_top      = val[WIN_W-1:0];
                REG_WINDOW_BOTTOM: win_bottom   = val[WIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Predict the result item of one accepted pixel and advance the position.
        function void take_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] b, logic [PIX_W-1:0] a);
            res_t        e;
            int unsigned w;
            int unsigned h;
            int unsigned right;
            int unsigned bottom;
            int unsigned su;
            int unsigned sv;
            bit          visible;
            bit          row_end;

            w       = clamp_dim(frame_width);
            h       = clamp_dim(frame_height);
            right   = (win_right < w - 1) ? win_right : w - 1;
            bottom  = (win_bottom < h - 1) ? win_bottom : h - 1;
            visible = col >= win_left && col <= right && row >= win_top && row <= bottom;
            e = '0;
            if (visible)
            begin
                e.masked_red   = r;
                e.masked_green = g;
                e.masked_blue  = b;
                e.masked_alpha = a;
            end
            else
                masked_pixels++;

            e.luma = 8'((scaled(COEF_Y_R, e.masked_red) + scaled(COEF_Y_G, e.masked_green)
                         + scaled(COEF_Y_B, e.masked_blue)) >> FRAC_BITS);

            e.chroma_valid = (row % 2 == 1) && (col % 2 == 1);
            if (e.chroma_valid)
            begin
                su = 32'(CHROMA_BIAS) + (32'(e.masked_blue) << HALF_SHIFT)
                     - scaled(COEF_U_R, e.masked_red) - scaled(COEF_U_G, e.masked_green);
                sv = 32'(CHROMA_BIAS) + (32'(e.masked_red) << HALF_SHIFT)
                     - scaled(COEF_V_G, e.masked_green) - scaled(COEF_V_B, e.masked_blue);
                e.chroma_blue = 8'(su >> FRAC_BITS);
                e.chroma_red  = 8'(sv >> FRAC_BITS);
                chroma_samples++;
            end

            row_end      = col >= w - 1;
            e.frame_last = row_end && row >= h - 1;
            if (e.frame_last)
            begin
                col = 0;
                row = 0;
                frames_done++;
            end
            else if (row_end)
            begin
                col = 0;
                row++;
            end
            else
                col++;

            expected_yuv.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("[%0t] mismatch at result %0d, %s: got %0d, expected %0d",
                         $time, checked, what, got, want);
        endtask

        task compare(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
            if (got !== want)
                report(what, got, want);
        endtask

        task check_result(res_t got);
            res_t e;
            checked++;
            if (expected_yuv.size() == 0)
            begin
                report("result with no pixel outstanding", 1, 0);
                return;
            end
            e = expected_yuv.pop_front();
            compare("masked_red",   got.masked_red,   e.masked_red);
            compare("masked_green", got.masked_green, e.masked_green);
            compare("masked_blue",  got.masked_blue,  e.masked_blue);
            compare("masked_alpha", got.masked_alpha, e.masked_alpha);
            compare("luma",         got.luma,         e.luma);
            compare("chroma_blue",  got.chroma_blue,  e.chroma_blue);
            compare("chroma_red",   got.chroma_red,   e.chroma_red);
            compare("chroma_valid", got.chroma_valid, e.chroma_valid);
            compare("frame_last",   got.frame_last,   e.frame_last);
        endtask
    endclass

endpackage

// ----- test/masked_rgba_to_yuv420_converter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for masked_rgba_to_yuv420_converter: directed corner
// pixels, then random frames and windows under random source gaps and sink stalls.
// Depends on rgb2yuv_pkg, the channel interfaces and yuv_check_pkg.
module masked_rgba_to_yuv420_converter_tb;
    import rgb2yuv_pkg::*;
    import yuv_check_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1950;
    // cycles with no handshake at all before the run is declared hung; the
    // worst legal quiet stretch is a long sink stall or a long gap plus
    // the settle pause, so this is far beyond any correct run
    localparam int unsigned IDLE_LIMIT   = 2000;
    // two-stage pipeline; wait out this pause before touching registers
    localparam int unsigned SETTLE       = 4;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    rgb2yuv_pixel_if  pixel_ch ();
    rgb2yuv_result_if result_ch ();
    rgb2yuv_cfg_if    cfg_ch ();

    masked_rgba_to_yuv420_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    yuv_scoreboard sb;
    int unsigned   quiet_cycles  = 0;
    int unsigned   random_items  = 0;
    int unsigned   directed_items = 0;
    int unsigned   cfg_phases    = 0;

    // ------------------------------------------------------------------
    // Sink stalls: the pattern switches between always ready, light and
    // heavy random stalls, and rare long stall runs.
    // ------------------------------------------------------------------
    int unsigned stall_mode = 0;
    int unsigned stall_run  = 0;
    int unsigned sink_cycle = 0;

    always @(posedge clk)
    begin
        sink_cycle++;
        if (sink_cycle % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        if (stall_run > 0)
        begin
            stall_run--;
            result_ch.ready <= 1'b0;
        end
        else
            case (stall_mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                2: result_ch.ready <= ($urandom_range(0, 1) != 0);
                default:
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_run = $urandom_range(4, 20);
                        result_ch.ready <= 1'b0;
                    end
                    else
                        result_ch.ready <= 1'b1;
            endcase
    end

    // ------------------------------------------------------------------
    // Monitor: every handshake is sampled at the edge it happens on. All
    // bench drives are nonblocking, so the values seen here are the ones
    // the block saw at this edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.apply_write(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
            if (pixel_ch.valid && pixel_ch.ready)
                sb.take_pixel(pixel_ch.red, pixel_ch.green, pixel_ch.blue, pixel_ch.alpha);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(res_t'({result_ch.masked_red, result_ch.masked_green,
                                        result_ch.masked_blue, result_ch.masked_alpha,
                                        result_ch.luma, result_ch.chroma_blue,
                                        result_ch.chroma_red, result_ch.chroma_valid,
                                        result_ch.frame_last}));
            if ((cfg_ch.valid && cfg_ch.ready) || (pixel_ch.valid && pixel_ch.ready)
                || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Hang detector: ends the run when nothing moves for too long.
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Timeout: %0d cycles without a handshake, %0d results outstanding",
                 IDLE_LIMIT, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Components lean toward the rails now and then so every bit flips.
    function automatic logic [7:0] rand_level();
        if ($urandom_range(0, 7) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    // Register values from the corners of the 13-bit field.
    function automatic logic [CFG_DATA_W-1:0] corner_value();
        case ($urandom_range(0, 6))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd2;
            3:       return 13'd4095;
            4:       return 13'd4096;
            5:       return 13'd4097;
            default: return 13'd8191;
        endcase
    endfunction

    // Holds valid until the pixel is taken; returns at the accepting edge.
    task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        pixel_ch.valid <= 1'b1;
        pixel_ch.red   <= r;
        pixel_ch.green <= g;
        pixel_ch.blue  <= b;
        pixel_ch.alpha <= a;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    task automatic hold_off(input int unsigned cycles);
        pixel_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result item. The first
    // edge lets the monitor book the pixel accepted at the calling step.
    task automatic drain();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg valid high; the caller lowers it after the last write.
    task automatic load_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                             input logic [CFG_DATA_W-1:0] left, input logic [CFG_DATA_W-1:0] right,
                             input logic [CFG_DATA_W-1:0] top, input logic [CFG_DATA_W-1:0] bottom);
        load_reg(REG_FRAME_WIDTH, fw);
        load_reg(REG_FRAME_HEIGHT, fh);
        load_reg(REG_WINDOW_LEFT, left);
        load_reg(REG_WINDOW_RIGHT, right);
        load_reg(REG_WINDOW_TOP, top);
        load_reg(REG_WINDOW_BOTTOM, bottom);
        cfg_ch.valid <= 1'b0;
        cfg_phases++;
    endtask

    // Random pixels in bursts; between bursts either no gap, a short or a
    // long gap, or now and then a full stop until the pipeline is empty.
    task automatic stream_pixels(input int unsigned count);
        int unsigned burst;
        while (count > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > count)
                burst = count;
            count -= burst;
            repeat (burst) push_pixel(rand_level(), rand_level(), rand_level(), rand_level());
            random_items += burst;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                8:       hold_off($urandom_range(8, 14));
                9:       drain();
                default: hold_off($urandom_range(1, 4));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned pick;
        int unsigned fw;
        int unsigned fh;
        int unsigned count;

        sb = new();
        rst_n = 1'b0;
        pixel_ch.valid  <= 1'b0;
        pixel_ch.red    <= '0;
        pixel_ch.green  <= '0;
        pixel_ch.blue   <= '0;
        pixel_ch.alpha  <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_FRAME_WIDTH;
        cfg_ch.data     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // reset geometry (1280x720, full window): white, black, pure red
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        push_pixel(8'hFF, 8'h00, 8'h00, 8'h80);
        drain();
        repeat (SETTLE) @(posedge clk);

        // shrink to 2x2 mid-row: column 3 now lies past the frame, so that
        // pixel is blacked out and closes row 0; the next two finish the frame
        set_frame(13'd2, 13'd2, 13'd0, 13'd1, 13'd0, 13'd1);
        push_pixel(8'd200, 8'd100, 8'd50, 8'd25);
        push_pixel(8'd1, 8'd2, 8'd3, 8'd4);
        push_pixel(8'd128, 8'd128, 8'd128, 8'd128);

        // whole 2x2 frames with rail colors on the chroma site
        repeat (3) push_pixel(rand_level(), rand_level(), rand_level(), rand_level());
        push_pixel(8'hFF, 8'h00, 8'h00, 8'hFF);
        repeat (3) push_pixel(rand_level(), rand_level(), rand_level(), rand_level());
        push_pixel(8'h00, 8'hFF, 8'hFF, 8'h00);
        repeat (3) push_pixel(rand_level(), rand_level(), rand_level(), rand_level());
        push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drain();
        repeat (SETTLE) @(posedge clk);

        // empty window (left past right, top past bottom): all black, and
        // the chroma site gives the chroma of black
        set_frame(13'd2, 13'd2, 13'd1, 13'd0, 13'd1, 13'd0);
        repeat (4) push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drain();
        repeat (SETTLE) @(posedge clk);

        // zero width acts as 1, oversize height as the maximum; window edges
        // past the frame are clamped and the bottom loses its 13th bit
        set_frame(13'd0, 13'd8191, 13'd0, 13'd4095, 13'd0, 13'd8191);
        push_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C);
        push_pixel(8'h5A, 8'hA5, 8'h3C, 8'hC3);
        directed_items = 24;

        // --- random part: configuration phases, each followed by a stream ---
        while (random_items < RANDOM_ITEMS)
        begin
            drain();
            repeat (SETTLE) @(posedge clk);
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                // small frames so rows, chroma sites and frame ends come often;
                // window edges may reach past the frame or cross each other
                fw = $urandom_range(1, 12);
                fh = $urandom_range(1, 10);
                set_frame(13'(fw), 13'(fh),
                          13'($urandom_range(0, fw)), 13'($urandom_range(0, fw + 3)),
                          13'($urandom_range(0, fh)), 13'($urandom_range(0, fh + 3)));
                count = $urandom_range(16, 160);
            end
            else if (pick < 8)
            begin
                set_frame(corner_value(), corner_value(), corner_value(),
                          corner_value(), corner_value(), corner_value());
                count = $urandom_range(8, 40);
            end
            else if (pick == 8)
            begin
                set_frame(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                          13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                          13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)));
                count = $urandom_range(8, 40);
            end
            else
            begin
                // move only the window; the position inside the frame carries on
                load_reg(REG_WINDOW_LEFT, 13'($urandom_range(0, 8)));
                load_reg(REG_WINDOW_TOP, 13'($urandom_range(0, 6)));
                if ($urandom_range(0, 1) != 0)
                    load_reg(REG_WINDOW_RIGHT, 13'($urandom_range(0, 12)));
                else
                    load_reg(REG_WINDOW_BOTTOM, 13'($urandom_range(0, 10)));
                cfg_ch.valid <= 1'b0;
                cfg_phases++;
                count = $urandom_range(16, 120);
            end
            stream_pixels(count);
        end

        // let the pipeline empty, then wait out the settle pause and check for strays
        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0)
            sb.report("result items never delivered", sb.pending(), 0);

        $display("Run: %0d pixels (%0d directed, %0d random), %0d results checked, %0d chroma sites,",
                 directed_items + random_items, directed_items, random_items,
                 sb.checked, sb.chroma_samples);
        $display("     %0d frame ends, %0d masked pixels, %0d register writes in %0d setups",
                 sb.frames_done, sb.masked_pixels, sb.reg_writes, cfg_phases);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
